// ===== hdl/suart_pkg.sv =====
// Shared types and constants for the soft UART with parity.
`default_nettype none
package suart_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_BIT_TICKS   = 2'd0;
    localparam logic [1:0] REG_DATA_BITS   = 2'd1;
    localparam logic [1:0] REG_PARITY_MODE = 2'd2;

    // Parity mode codes
    localparam logic [1:0] PAR_NONE = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_ODD  = 2'd2;

    localparam int unsigned MAX_DATA_BITS = 9;
    localparam int unsigned MIN_DATA_BITS = 5;
    localparam int unsigned FRAME_W       = MAX_DATA_BITS + 3;

    // Register reset values
    localparam logic [15:0] BIT_TICKS_RESET   = 16'd208;
    localparam logic [3:0]  DATA_BITS_RESET   = 4'd8;
    localparam logic [1:0]  PARITY_MODE_RESET = PAR_NONE;

    // Effective configuration, already clamped
    typedef struct packed {
        logic [15:0] ticks;
        logic [3:0]  nbits;
        logic        parity_on;
        logic        parity_odd;
    } cfg_t;

    // Classified tick request handed from front to back
    typedef struct packed {
        logic                 rx_line;
        logic                 send_request;
        logic [FRAME_W-1:0]   frame;
        logic [3:0]           frame_len;
    } item_t;

    // One result per tick
    typedef struct packed {
        logic                     tx_line;
        logic                     tx_busy;
        logic                     rx_valid;
        logic [MAX_DATA_BITS-1:0] rx_word;
    } result_t;

    // Mask with the low nbits bits set
    function automatic logic [MAX_DATA_BITS-1:0] word_mask(input logic [3:0] nbits);
        logic [MAX_DATA_BITS-1:0] m;
        for (int i = 0; i < MAX_DATA_BITS; i++)
        begin
            m[i] = (4'(i) < nbits);
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/soft_uart_with_parity.sv =====
// Soft UART with parity: tick request queue, UART engines, result queue.
// A request accepted into the front queue is stepped through the engines when the result
// queue has room, and its result is registered into the result queue, where it can be popped.
// Throughput: one request per clock when neither queue stalls; the front queue and the
// result queue each hold two entries, so a stall on one side need not stop the other at once.
// Reset (rst_n low, asynchronous): both queues empty, registers at their defaults,
// transmitter idle with the line high, receiver idle.
`default_nettype none
module soft_uart_with_parity (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic        rx_line,
    input  wire logic        send_request,
    input  wire logic [8:0]  send_word,
    output logic             empty,
    input  wire logic        pop,
    output logic             tx_line,
    output logic             tx_busy,
    output logic             rx_valid,
    output logic [8:0]       rx_word
);

    suart_pkg::cfg_t    cfg;
    suart_pkg::item_t   item;
    suart_pkg::result_t result;
    logic               item_valid;
    logic               item_pop;

    suart_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    suart_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_line      (rx_line),
        .send_request (send_request),
        .send_word    (send_word),
        .cfg          (cfg),
        .item_valid   (item_valid),
        .item         (item),
        .item_pop     (item_pop)
    );

    suart_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign tx_line  = result.tx_line;
    assign tx_busy  = result.tx_busy;
    assign rx_valid = result.rx_valid;
    assign rx_word  = result.rx_word;

`ifndef NO_ASSERTIONS
    // An idle transmitter drives the line high
    a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !tx_busy) |-> tx_line)
        else $error("transmit line low while idle");

    // Received word is zero unless it is valid
    a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rx_valid) |-> (rx_word == 9'd0))
        else $error("received word set without valid");

    // Effective word length stays within its legal range
    a_nbits_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.nbits >= 4'd5) && (cfg.nbits <= 4'd9))
        else $error("effective data length out of range");

    // A request only leaves the front queue when one is waiting
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item_valid)
        else $error("front queue popped while empty");
`endif

endmodule
`default_nettype wire

// ===== hdl/suart_regs.sv =====
// Configuration registers and their clamped effective values.
`default_nettype none
module suart_regs (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    output suart_pkg::cfg_t         cfg
);

    logic [15:0] bit_ticks_reg;
    logic [3:0]  data_bits_reg;
    logic [1:0]  parity_mode_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg   <= suart_pkg::BIT_TICKS_RESET;
            data_bits_reg   <= suart_pkg::DATA_BITS_RESET;
            parity_mode_reg <= suart_pkg::PARITY_MODE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                suart_pkg::REG_BIT_TICKS:   bit_ticks_reg   <= cfg_wdata;
                suart_pkg::REG_DATA_BITS:   data_bits_reg   <= cfg_wdata[3:0];
                suart_pkg::REG_PARITY_MODE: parity_mode_reg <= cfg_wdata[1:0];
                default:                    ;
            endcase
        end
    end

    // Clamp bit time and word length, map the unused parity code to none
    always_comb
    begin
        cfg.ticks = (bit_ticks_reg < 16'd2) ? 16'd2 : bit_ticks_reg;
        if (data_bits_reg < 4'(suart_pkg::MIN_DATA_BITS))
            cfg.nbits = 4'(suart_pkg::MIN_DATA_BITS);
        else if (data_bits_reg > 4'(suart_pkg::MAX_DATA_BITS))
            cfg.nbits = 4'(suart_pkg::MAX_DATA_BITS);
        else
            cfg.nbits = data_bits_reg;
        cfg.parity_on  = (parity_mode_reg == suart_pkg::PAR_EVEN) ||
                         (parity_mode_reg == suart_pkg::PAR_ODD);
        cfg.parity_odd = (parity_mode_reg == suart_pkg::PAR_ODD);
    end

endmodule
`default_nettype wire

// ===== hdl/suart_front.sv =====
// Front end: accepts tick requests, builds the transmit frame, queues them.
`default_nettype none
module suart_front (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    rx_line,
    input  wire logic                    send_request,
    input  wire logic [8:0]              send_word,
    input  wire suart_pkg::cfg_t         cfg,
    output logic                         item_valid,
    output suart_pkg::item_t             item,
    input  wire logic                    item_pop
);

    localparam int unsigned FW = suart_pkg::FRAME_W;

    suart_pkg::item_t q_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    suart_pkg::item_t         new_item;
    logic [8:0]               word_m;
    logic                     par_bit;
    logic [3:0]               len;
    logic                     do_push;

    // Build start, data, parity, stop and idle bits for the request
    always_comb
    begin
        word_m  = send_word & suart_pkg::word_mask(cfg.nbits);
        par_bit = (^word_m) ^ cfg.parity_odd;
        len     = cfg.nbits + 4'd2 + {3'b0, cfg.parity_on};
        new_item.rx_line      = rx_line;
        new_item.send_request = send_request;
        new_item.frame_len    = len;
        new_item.frame        = (FW'(word_m) << 1)
                              | ((cfg.parity_on ? FW'(par_bit) : '0) << (cfg.nbits + 4'd1))
                              | ({FW{1'b1}} << (len - 4'd1));
    end

    assign full       = (count_reg == 2'd2);
    assign do_push    = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ item_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, item_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= new_item;
    end

endmodule
`default_nettype wire

// ===== hdl/suart_back.sv =====
// Back end: transmit and receive engines, one tick per request, result queue.
`default_nettype none
module suart_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire suart_pkg::cfg_t         cfg,
    input  wire logic                    item_valid,
    input  wire suart_pkg::item_t        item,
    output logic                         item_pop,
    output logic                         empty,
    input  wire logic                    pop,
    output suart_pkg::result_t           result
);

    localparam int unsigned FW = suart_pkg::FRAME_W;

    typedef enum logic [2:0] {
        RX_IDLE  = 3'b001,
        RX_START = 3'b010,
        RX_DATA  = 3'b100
    } rx_phase_t;

    logic [FW-1:0] tx_shift_reg, tx_shift_next;
    logic [3:0]    tx_bits_left_reg, tx_bits_left_next;
    logic [15:0]   tx_tick_reg, tx_tick_next;
    rx_phase_t     rx_phase_reg, rx_phase_next;
    logic [15:0]   rx_tick_reg, rx_tick_next;
    logic [3:0]    rx_index_reg, rx_index_next;
    logic [9:0]    rx_shift_reg, rx_shift_next;
    logic          rx_prev_reg;

    suart_pkg::result_t out_mem [2];
    logic       out_wr_reg, out_rd_reg;
    logic [1:0] out_count_reg, out_count_next;

    suart_pkg::result_t res;
    logic [15:0]        tx_tick_inc, rx_tick_inc;
    logic               step, take;

    // Step one tick when a request waits and the result queue has room
    assign take     = pop && !empty;
    assign step     = item_valid && ((out_count_reg != 2'd2) || take);
    assign item_pop = step;
    assign empty    = (out_count_reg == 2'd0);
    assign result   = out_mem[out_rd_reg];

    // Transmitter: advance the current frame, then load a new one if free
    always_comb
    begin
        tx_shift_next     = tx_shift_reg;
        tx_bits_left_next = tx_bits_left_reg;
        tx_tick_next      = tx_tick_reg;
        tx_tick_inc       = tx_tick_reg + 16'd1;
        if (tx_bits_left_reg != 4'd0)
        begin
            if (tx_tick_inc >= cfg.ticks)
            begin
                tx_tick_next      = 16'd0;
                tx_shift_next     = {1'b1, tx_shift_reg[FW-1:1]};
                tx_bits_left_next = tx_bits_left_reg - 4'd1;
            end
            else
            begin
                tx_tick_next = tx_tick_inc;
            end
        end
        if ((tx_bits_left_next == 4'd0) && item.send_request)
        begin
            tx_shift_next     = item.frame;
            tx_bits_left_next = item.frame_len;
            tx_tick_next      = 16'd0;
        end
    end

    // Receiver: edge detect, half-bit wait, mid-bit sampling
    always_comb
    begin
        rx_phase_next = rx_phase_reg;
        rx_tick_next  = rx_tick_reg;
        rx_index_next = rx_index_reg;
        rx_shift_next = rx_shift_reg;
        rx_tick_inc   = rx_tick_reg + 16'd1;
        res.rx_valid  = 1'b0;
        res.rx_word   = '0;
        case (rx_phase_reg)
            RX_START:
            begin
                rx_tick_next = rx_tick_inc;
                if (rx_tick_inc >= {1'b0, cfg.ticks[15:1]})
                begin
                    rx_phase_next = RX_DATA;
                    rx_tick_next  = 16'd0;
                    rx_index_next = 4'd0;
                    rx_shift_next = 10'd0;
                end
            end
            RX_DATA:
            begin
                rx_tick_next = rx_tick_inc;
                if (rx_tick_inc >= cfg.ticks)
                begin
                    rx_tick_next = 16'd0;
                    if (rx_index_reg < 4'd10)
                        rx_shift_next = rx_shift_reg
                                      | (10'(item.rx_line) << rx_index_reg);
                    rx_index_next = rx_index_reg + 4'd1;
                    if (rx_index_next >= (cfg.nbits + {3'b0, cfg.parity_on}))
                    begin
                        res.rx_valid  = 1'b1;
                        res.rx_word   = rx_shift_next[8:0]
                                      & suart_pkg::word_mask(cfg.nbits);
                        rx_phase_next = RX_IDLE;
                        rx_index_next = 4'd0;
                    end
                end
            end
            default:
            begin
                rx_phase_next = RX_IDLE;
                if (rx_prev_reg && !item.rx_line)
                begin
                    rx_phase_next = RX_START;
                    rx_tick_next  = 16'd0;
                end
            end
        endcase
        res.tx_line = (tx_bits_left_next != 4'd0) ? tx_shift_next[0] : 1'b1;
        res.tx_busy = (tx_bits_left_next != 4'd0);
    end

    assign out_count_next = out_count_reg + {1'b0, step} - {1'b0, take};

    // Update engine state on each tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg     <= '1;
            tx_bits_left_reg <= 4'd0;
            tx_tick_reg      <= 16'd0;
            rx_phase_reg     <= RX_IDLE;
            rx_tick_reg      <= 16'd0;
            rx_index_reg     <= 4'd0;
            rx_shift_reg     <= 10'd0;
            rx_prev_reg      <= 1'b1;
            out_wr_reg       <= 1'b0;
            out_rd_reg       <= 1'b0;
            out_count_reg    <= 2'd0;
        end
        else
        begin
            if (step)
            begin
                tx_shift_reg     <= tx_shift_next;
                tx_bits_left_reg <= tx_bits_left_next;
                tx_tick_reg      <= tx_tick_next;
                rx_phase_reg     <= rx_phase_next;
                rx_tick_reg      <= rx_tick_next;
                rx_index_reg     <= rx_index_next;
                rx_shift_reg     <= rx_shift_next;
                rx_prev_reg      <= item.rx_line;
            end
            out_wr_reg    <= out_wr_reg ^ step;
            out_rd_reg    <= out_rd_reg ^ take;
            out_count_reg <= out_count_next;
        end
    end

    // Hold the result until popped
    always_ff @(posedge clk)
    begin
        if (step)
            out_mem[out_wr_reg] <= res;
    end

endmodule
`default_nettype wire

// ===== dv/soft_uart_checker.sv =====
// Tick checker for the soft UART: predicts every tick result and compares it on pop.
`default_nettype none
module soft_uart_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic        rx_line,
    input  wire logic        send_request,
    input  wire logic [8:0]  send_word,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic        tx_line,
    input  wire logic        tx_busy,
    input  wire logic        rx_valid,
    input  wire logic [8:0]  rx_word,
    output int               outstanding,
    output int               errors,
    output int               frames_sent,
    output int               words_received
);

    typedef enum logic [2:0] {
        RX_IDLE  = 3'b001,
        RX_START = 3'b010,
        RX_DATA  = 3'b100
    } rx_phase_t;

    // Register shadow
    logic [15:0] reg_ticks;
    logic [3:0]  reg_bits;
    logic [1:0]  reg_parity;

    // Transmitter shadow
    logic [11:0] tx_sr;
    logic [3:0]  tx_left;
    logic [15:0] tx_cnt;

    // Receiver shadow
    rx_phase_t   rx_phase;
    logic [15:0] rx_cnt;
    logic [3:0]  rx_idx;
    logic [9:0]  rx_sr;
    logic        rx_last;

    suart_pkg::result_t tick_results[$];

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] tick result: %s", $time, msg);
    endtask

    // Advance both UART halves by one tick and form the expected result
    task automatic predict_tick(input logic line, input logic req, input logic [8:0] word,
                                output suart_pkg::result_t res);
        logic [16:0] ticks;
        logic [3:0]  nbits;
        logic        pon;
        logic [8:0]  mask;
        logic [8:0]  d;
        logic [31:0] frame;
        logic [3:0]  len;
        logic        par;
        logic [3:0]  total;
        ticks = (reg_ticks < 16'd2) ? 17'd2 : {1'b0, reg_ticks};
        if (reg_bits < 4'(suart_pkg::MIN_DATA_BITS))
            nbits = 4'(suart_pkg::MIN_DATA_BITS);
        else if (reg_bits > 4'(suart_pkg::MAX_DATA_BITS))
            nbits = 4'(suart_pkg::MAX_DATA_BITS);
        else
            nbits = reg_bits;
        pon  = (reg_parity == suart_pkg::PAR_EVEN) || (reg_parity == suart_pkg::PAR_ODD);
        mask = 9'((32'd1 << nbits) - 32'd1);
        res  = '0;

        // advance the frame in flight
        if (tx_left != 4'd0)
        begin
            tx_cnt = tx_cnt + 16'd1;
            if ({1'b0, tx_cnt} >= ticks)
            begin
                tx_cnt  = 16'd0;
                tx_sr   = {1'b1, tx_sr[11:1]};
                tx_left = tx_left - 4'd1;
            end
        end

        // load a new frame: start bit, data, optional parity, stop bit
        if (tx_left == 4'd0 && req)
        begin
            d     = word & mask;
            frame = 32'(d) << 1;
            len   = nbits + 4'd2;
            if (pon)
            begin
                par   = (^d) ^ (reg_parity == suart_pkg::PAR_ODD);
                frame = frame | (32'(par) << (nbits + 4'd1));
                len   = len + 4'd1;
            end
            frame   = frame | (32'd1 << (len - 4'd1));
            tx_sr   = 12'(frame | ~((32'd1 << len) - 32'd1));
            tx_left = len;
            tx_cnt  = 16'd0;
            frames_sent++;
        end

        // receiver: half-bit wait, then one sample per bit time
        case (rx_phase)
            RX_START:
            begin
                rx_cnt = rx_cnt + 16'd1;
                if ({1'b0, rx_cnt} >= (ticks >> 1))
                begin
                    rx_phase = RX_DATA;
                    rx_cnt   = 16'd0;
                    rx_idx   = 4'd0;
                    rx_sr    = 10'd0;
                end
            end
            RX_DATA:
            begin
                total  = nbits + 4'(pon);
                rx_cnt = rx_cnt + 16'd1;
                if ({1'b0, rx_cnt} >= ticks)
                begin
                    rx_cnt = 16'd0;
                    if (rx_idx < 4'd10)
                        rx_sr = rx_sr | (10'(line) << rx_idx);
                    rx_idx = rx_idx + 4'd1;
                    if (rx_idx >= total)
                    begin
                        res.rx_valid = 1'b1;
                        res.rx_word  = rx_sr[8:0] & mask;
                        rx_phase     = RX_IDLE;
                        rx_idx       = 4'd0;
                        words_received++;
                    end
                end
            end
            default:
            begin
                rx_phase = RX_IDLE;
                if (rx_last && !line)
                begin
                    rx_phase = RX_START;
                    rx_cnt   = 16'd0;
                end
            end
        endcase
        rx_last = line;

        res.tx_line = (tx_left != 4'd0) ? tx_sr[0] : 1'b1;
        res.tx_busy = (tx_left != 4'd0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        suart_pkg::result_t want;
        suart_pkg::result_t fresh;
        if (!rst_n)
        begin
            reg_ticks      = suart_pkg::BIT_TICKS_RESET;
            reg_bits       = suart_pkg::DATA_BITS_RESET;
            reg_parity     = suart_pkg::PARITY_MODE_RESET;
            tx_sr          = 12'hFFF;
            tx_left        = 4'd0;
            tx_cnt         = 16'd0;
            rx_phase       = RX_IDLE;
            rx_cnt         = 16'd0;
            rx_idx         = 4'd0;
            rx_sr          = 10'd0;
            rx_last        = 1'b1;
            errors         = 0;
            frames_sent    = 0;
            words_received = 0;
            tick_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // mirror register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    suart_pkg::REG_BIT_TICKS:   reg_ticks  = cfg_wdata;
                    suart_pkg::REG_DATA_BITS:   reg_bits   = cfg_wdata[3:0];
                    suart_pkg::REG_PARITY_MODE: reg_parity = cfg_wdata[1:0];
                    default: ;
                endcase
            end

            // compare a popped result with the oldest prediction
            if (pop && !empty)
            begin
                if (tick_results.size() == 0)
                begin
                    report_mismatch("result popped with no request outstanding");
                end
                else
                begin
                    want = tick_results.pop_front();
                    if (tx_line !== want.tx_line)
                        report_mismatch($sformatf("tx_line expected %0b got %0b",
                                                  want.tx_line, tx_line));
                    if (tx_busy !== want.tx_busy)
                        report_mismatch($sformatf("tx_busy expected %0b got %0b",
                                                  want.tx_busy, tx_busy));
                    if (rx_valid !== want.rx_valid)
                        report_mismatch($sformatf("rx_valid expected %0b got %0b",
                                                  want.rx_valid, rx_valid));
                    if (rx_word !== want.rx_word)
                        report_mismatch($sformatf("rx_word expected 0x%03h got 0x%03h",
                                                  want.rx_word, rx_word));
                end
            end

            // predict each accepted request
            if (push && !full)
            begin
                predict_tick(rx_line, send_request, send_word, fresh);
                tick_results.push_back(fresh);
            end

            outstanding <= tick_results.size();
        end
    end

endmodule
`default_nettype wire

// ===== dv/soft_uart_with_parity_test.sv =====
// Top of the soft UART test: clock, reset, tick and register stimulus, and the verdict.
`default_nettype none
module soft_uart_with_parity_test;

    localparam int unsigned TICK_TARGET  = 1500;
    localparam int unsigned LIMIT_CYCLES = 400000;
    localparam logic [1:0]  REG_UNUSED   = 2'd3;
    localparam logic [1:0]  PAR_UNUSED   = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        push;
    logic        full;
    logic        rx_line;
    logic        send_request;
    logic [8:0]  send_word;
    logic        empty;
    logic        pop;
    logic        tx_line;
    logic        tx_busy;
    logic        rx_valid;
    logic [8:0]  rx_word;

    int outstanding;
    int errors;
    int frames_sent;
    int words_received;

    int ticks_pushed;
    int settings_used;
    bit steady_in;
    bit steady_out;

    // Serial format the stimulus currently shapes frames for
    int   cur_ticks;
    int   cur_bits;
    logic cur_par;
    logic cur_odd;

    soft_uart_with_parity u_dut (.*);

    soft_uart_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("Run exceeded its time limit");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Offer one tick request after a random gap and hold it until accepted
    task automatic put_tick(input logic line, input logic req, input logic [8:0] word);
        int gap;
        gap = steady_in ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        rx_line      <= line;
        send_request <= req;
        send_word    <= word;
        @(posedge clk);
        while (full) @(posedge clk);
        ticks_pushed++;
    endtask

    // Tick with a given receive level and a random send request
    task automatic line_tick(input logic line);
        put_tick(line, $urandom_range(0, 2) == 0, 9'($urandom_range(0, 511)));
    endtask

    // Hold requests off until every predicted result has been popped
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Write all registers while the block is idle
    task automatic apply_settings(input logic [15:0] bt, input logic [3:0] nb,
                                  input logic [1:0] pm);
        drain();
        repeat (3) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_UNUSED;
        cfg_wdata <= 16'($urandom);
        @(posedge clk);
        cfg_index <= suart_pkg::REG_BIT_TICKS;
        cfg_wdata <= bt;
        @(posedge clk);
        cfg_index <= suart_pkg::REG_DATA_BITS;
        cfg_wdata <= 16'(nb);
        @(posedge clk);
        cfg_index <= suart_pkg::REG_PARITY_MODE;
        cfg_wdata <= 16'(pm);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_ticks = (bt < 16'd2) ? 2 : int'(bt);
        cur_bits  = (nb < 4'(suart_pkg::MIN_DATA_BITS)) ? int'(suart_pkg::MIN_DATA_BITS) :
                    (nb > 4'(suart_pkg::MAX_DATA_BITS)) ? int'(suart_pkg::MAX_DATA_BITS) :
                    int'(nb);
        cur_par   = (pm == suart_pkg::PAR_EVEN) || (pm == suart_pkg::PAR_ODD);
        cur_odd   = (pm == suart_pkg::PAR_ODD);
        steady_in  = ($urandom_range(0, 3) == 0);
        steady_out = ($urandom_range(0, 3) == 0);
        settings_used++;
    endtask

    // Drive one serial frame on the receive line, sometimes cut short, with a bad parity bit or a short stop bit
    task automatic drive_frame();
        logic [8:0]  data;
        logic [8:0]  mask;
        logic [11:0] lv;
        int          n;
        int          cut;
        int          stop_len;
        data = 9'($urandom_range(0, 511));
        mask = 9'((32'd1 << cur_bits) - 32'd1);
        lv   = '1;
        lv[0] = 1'b0;
        for (int i = 0; i < cur_bits; i++)
        begin
            lv[1 + i] = data[i];
        end
        n = 1 + cur_bits;
        if (cur_par)
        begin
            lv[n] = (^(data & mask)) ^ cur_odd ^ ($urandom_range(0, 7) == 0);
            n++;
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
        for (int b = 0; b < cut; b++)
        begin
            repeat (cur_ticks) line_tick(lv[b]);
        end
        if ($urandom_range(0, 7) == 0)
            stop_len = $urandom_range(0, cur_ticks - 1);
        else
            stop_len = cur_ticks * $urandom_range(1, 2);
        repeat (stop_len) line_tick(1'b1);
    endtask

    // Mostly well-formed frames, with noise, idle line and an occasional full drain
    task automatic run_phase(input int budget);
        int first;
        int pick;
        first = ticks_pushed;
        while (ticks_pushed - first < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70 && cur_ticks <= 16)
                drive_frame();
            else if (pick < 85)
                repeat ($urandom_range(1, 8)) line_tick(1'($urandom_range(0, 1)));
            else if (pick < 98)
                repeat ($urandom_range(1, 4)) line_tick(1'b1);
            else
                drain();
        end
    endtask

    // Result side: pop with random stalls
    initial
    begin : result_sink
        int hold;
        pop = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            hold = steady_out ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        logic [15:0] bt_plan[8];
        logic [3:0]  nb_plan[8];
        logic [1:0]  pm_plan[8];
        bt_plan = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'd4, 16'd5, 16'd7};
        nb_plan = '{4'd0, 4'd15, 4'd5, 4'd9, 4'd8, 4'd4, 4'd10, 4'd8};
        pm_plan = '{PAR_UNUSED, suart_pkg::PAR_EVEN, suart_pkg::PAR_ODD, suart_pkg::PAR_EVEN,
                    suart_pkg::PAR_NONE, suart_pkg::PAR_ODD, suart_pkg::PAR_NONE,
                    suart_pkg::PAR_EVEN};

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = suart_pkg::REG_BIT_TICKS;
        cfg_wdata    = 16'd0;
        push         = 1'b0;
        rx_line      = 1'b1;
        send_request = 1'b0;
        send_word    = 9'd0;
        ticks_pushed  = 0;
        settings_used = 0;
        steady_in     = 1'b0;
        steady_out    = 1'b0;
        cur_ticks     = int'(suart_pkg::BIT_TICKS_RESET);
        cur_bits      = int'(suart_pkg::DATA_BITS_RESET);
        cur_par       = 1'b0;
        cur_odd       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, full and empty words, request while busy,
        // start bit that rises again before the half-bit point
        put_tick(1'b1, 1'b0, 9'h000);
        put_tick(1'b1, 1'b1, 9'h1FF);
        put_tick(1'b1, 1'b1, 9'h000);
        put_tick(1'b0, 1'b0, 9'h1FF);
        put_tick(1'b1, 1'b1, 9'h0AA);
        put_tick(1'b1, 1'b0, 9'h155);
        put_tick(1'b0, 1'b1, 9'h1FF);
        put_tick(1'b0, 1'b0, 9'h000);

        // Planned settings: clamped values, widest bit time, every parity code
        for (int p = 0; p < 8; p++)
        begin
            apply_settings(bt_plan[p], nb_plan[p], pm_plan[p]);
            run_phase((bt_plan[p] > 16'd16) ? 40 : 150);
        end

        // Random settings, short bit times
        while (ticks_pushed < TICK_TARGET)
        begin
            apply_settings(16'($urandom_range(0, 9)), 4'($urandom_range(0, 15)),
                           2'($urandom_range(0, 3)));
            run_phase(150);
        end

        drain();
        repeat (8) @(posedge clk);

        $display("Ran %0d ticks across %0d register settings, bit times 2 to 65535.",
                 ticks_pushed, settings_used);
        $display("Transmitter started %0d frames; receiver delivered %0d words.",
                 frames_sent, words_received);
        if (errors == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/suart_pkg.sv
hdl/suart_regs.sv
hdl/suart_front.sv
hdl/suart_back.sv
hdl/soft_uart_with_parity.sv
dv/soft_uart_checker.sv
dv/soft_uart_with_parity_test.sv
